FILE: hdl/pcal_pkg.sv
package pcal_pkg;

  // Fixed field widths.
  localparam int DataW     = 12;
  localparam int RegW      = 32;
  localparam int ScaleFrac = 16;
  localparam int RegIdxW   = 2;

  // Result of the average-times-scale product and its shifted form.
  localparam int ProdW = DataW + RegW;
  localparam int ShW   = ProdW - ScaleFrac;

  // Reset values of the calibration registers.
  localparam logic signed [RegW-1:0] ScaleReset    = 32'sh0001_0000;
  localparam logic signed [RegW-1:0] OffsetReset   = 32'sh0000_0000;
  localparam logic signed [RegW-1:0] RangeMinReset = 32'sh8000_0000;
  localparam logic signed [RegW-1:0] RangeMaxReset = 32'sh7fff_ffff;

  typedef enum logic [RegIdxW-1:0] {
    REG_SCALE     = 2'd0,
    REG_OFFSET    = 2'd1,
    REG_RANGE_MIN = 2'd2,
    REG_RANGE_MAX = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [DataW-1:0] sample;
    logic                    device_ok;
  } in_item_t;

  typedef struct packed {
    logic signed [RegW-1:0] pressure;
    logic                   valid_res;
  } out_item_t;

  typedef struct packed {
    logic signed [RegW-1:0] scale;
    logic signed [RegW-1:0] offset;
    logic signed [RegW-1:0] range_min;
    logic signed [RegW-1:0] range_max;
  } calib_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: hdl/pcal_front.sv
module pcal_front import pcal_pkg::*; #(
  parameter int Samples = 8,
  parameter int SumW    = 15
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  in_item_t               in_item_i,
  input  logic                   q_full_i,
  output logic                   push_o,
  output logic signed [SumW-1:0] push_sum_o,
  output logic                   push_calc_o
);

  localparam int CntW = $clog2(Samples + 1);

  logic signed [DataW-1:0] ring_q [Samples];
  logic signed [SumW-1:0]  sum_q, sum_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic                    accept;
  logic                    take;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & in_ready_o;
  assign take       = accept & in_item_i.device_ok;

  // The ring is a shift line: the newest sample enters at the head and the
  // oldest one, which leaves the window, sits at the tail.
  always_comb begin
    sum_d = sum_q
          - {{(SumW-DataW){ring_q[Samples-1][DataW-1]}}, ring_q[Samples-1]}
          + {{(SumW-DataW){in_item_i.sample[DataW-1]}}, in_item_i.sample};
    cnt_d = (cnt_q == CntW'(Samples)) ? cnt_q : cnt_q + CntW'(1);
  end

  assign push_o      = accept;
  assign push_sum_o  = sum_d;
  assign push_calc_o = in_item_i.device_ok & (cnt_d == CntW'(Samples));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Samples; i++) begin
        ring_q[i] <= '0;
      end
      sum_q <= '0;
      cnt_q <= '0;
    end else if (take) begin
      ring_q[0] <= in_item_i.sample;
      for (int i = 1; i < Samples; i++) begin
        ring_q[i] <= ring_q[i-1];
      end
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: hdl/pcal_queue.sv
module pcal_queue import pcal_pkg::*; #(
  parameter int Width = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output q_status_t        status_o
);

  // Two entries: one in flight and one absorbing a stall of the back end.
  logic [Width-1:0] mem_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;

  assign data_o         = mem_q[rptr_q];
  assign status_o.full  = (cnt_q == 2'd2);
  assign status_o.empty = (cnt_q == 2'd0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

FILE: hdl/pcal_back.sv
module pcal_back import pcal_pkg::*; #(
  parameter int Samples = 8,
  parameter int SumW    = 15
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_empty_i,
  input  logic signed [SumW-1:0] q_sum_i,
  input  logic                   q_calc_i,
  output logic                   pop_o,
  input  calib_t                 calib_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output out_item_t              out_item_o
);

  // Division by Samples as a multiply by a rounded-up reciprocal. With the
  // shift one log2 above the magnitude width the quotient is exact.
  localparam int Lg    = $clog2(Samples);
  localparam int MagW  = SumW;
  localparam int Shift = MagW + Lg;
  localparam int RecW  = MagW + 2;
  localparam int PW    = MagW + RecW;
  localparam longint unsigned RecipL =
      ((64'd1 << Shift) + longint'(Samples) - 64'd1) / longint'(Samples);
  localparam logic [RecW-1:0] Recip = RecW'(RecipL);

  logic adv;

  logic            s1_v_q, s1_calc_q, s1_neg_q;
  logic [PW-1:0]   s1_prod_q;
  logic            s2_v_q, s2_calc_q;
  logic signed [ProdW-1:0] s2_prod_q;
  logic            s3_v_q, s3_calc_q;
  logic signed [RegW-1:0]  s3_press_q;
  logic            out_v_q;
  out_item_t       out_item_q;

  logic [MagW-1:0]         mag;
  logic [DataW-1:0]        avg_mag;
  logic signed [DataW-1:0] avg;
  logic signed [ProdW-1:0] prod2;
  logic signed [ShW-1:0]   shifted;
  logic signed [RegW:0]    wide_sum;
  logic signed [RegW-1:0]  sat;
  out_item_t               res;

  // The whole pipe moves together whenever the output register can take.
  assign adv   = ~out_v_q | out_ready_i;
  assign pop_o = adv & ~q_empty_i;

  always_comb begin
    mag     = q_sum_i[SumW-1] ? MagW'(~q_sum_i + SumW'(1)) : MagW'(q_sum_i);
    avg_mag = s1_prod_q[Shift +: DataW];
    avg     = s1_neg_q ? -$signed(avg_mag) : $signed(avg_mag);
    prod2   = $signed({{RegW{avg[DataW-1]}}, avg})
            * $signed({{DataW{calib_i.scale[RegW-1]}}, calib_i.scale});
    // Arithmetic shift rounds toward minus infinity.
    shifted  = s2_prod_q[ProdW-1:ScaleFrac];
    wide_sum = {{(RegW+1-ShW){shifted[ShW-1]}}, shifted}
             + {calib_i.offset[RegW-1], calib_i.offset};
    if (wide_sum[RegW] != wide_sum[RegW-1]) begin
      sat = wide_sum[RegW] ? {1'b1, {(RegW-1){1'b0}}} : {1'b0, {(RegW-1){1'b1}}};
    end else begin
      sat = wide_sum[RegW-1:0];
    end
    res.pressure  = s3_calc_q ? s3_press_q : '0;
    res.valid_res = s3_calc_q & (s3_press_q >= calib_i.range_min)
                  & (s3_press_q <= calib_i.range_max);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_calc_q  <= q_calc_i;
      s1_neg_q   <= q_sum_i[SumW-1];
      s1_prod_q  <= PW'(mag) * PW'(Recip);
      s2_calc_q  <= s1_calc_q;
      s2_prod_q  <= prod2;
      s3_calc_q  <= s2_calc_q;
      s3_press_q <= sat;
      out_item_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q  <= pop_o;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      out_v_q <= s3_v_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_item_q;

endmodule

FILE: hdl/oversampled_pressure_calibrator_core.sv
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+--------------------------------
// in       | input     | in_valid_i / in_ready_o    | in_item_i  (sample, device_ok)
// out      | output    | out_valid_o / out_ready_i  | out_item_o (pressure, valid_res)
// cfg      | input     | cfg_we_i (no wait)         | cfg_idx_i, cfg_data_i
//
// One transfer is taken per cycle while the queue has room, and one result is delivered
// per cycle while out_ready_i is high. A result passes through the queue and then
// the back-end pipe: reciprocal multiply, average times scale, shift with offset
// and saturation, and the output register.
// Reset clears the sample ring, the running sum and the fill count at once.
// A stall on the output freezes the back end; the two-entry queue keeps the
// front taking transfers until it fills, and in_ready_o then drops.
module oversampled_pressure_calibrator_core import pcal_pkg::*; #(
  parameter int SAMPLES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_item_o,
  input  logic               cfg_we_i,
  input  logic [RegIdxW-1:0] cfg_idx_i,
  input  logic [RegW-1:0]    cfg_data_i
);

  // The window sum spans Samples full-scale samples of either sign.
  localparam int SumW = DataW + $clog2(SAMPLES);
  localparam int QW   = SumW + 1;

  calib_t    calib_q;
  q_status_t q_status;

  logic                   push;
  logic signed [SumW-1:0] push_sum;
  logic                   push_calc;
  logic                   pop;
  logic [QW-1:0]          q_rd_data;

  // Calibration registers. The user must see that they are written only while the block
  // is idle, so the back end may read them directly; the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_q.scale     <= ScaleReset;
      calib_q.offset    <= OffsetReset;
      calib_q.range_min <= RangeMinReset;
      calib_q.range_max <= RangeMaxReset;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_SCALE:     calib_q.scale     <= cfg_data_i;
        REG_OFFSET:    calib_q.offset    <= cfg_data_i;
        REG_RANGE_MIN: calib_q.range_min <= cfg_data_i;
        REG_RANGE_MAX: calib_q.range_max <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The front end updates the window and marks whether a pressure is due.
  pcal_front #(
    .Samples (SAMPLES),
    .SumW    (SumW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .q_full_i    (q_status.full),
    .push_o      (push),
    .push_sum_o  (push_sum),
    .push_calc_o (push_calc)
  );

  pcal_queue #(
    .Width (QW)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   ({push_calc, push_sum}),
    .pop_i    (pop),
    .data_o   (q_rd_data),
    .status_o (q_status)
  );

  // The back end turns the window sum into a calibrated, range-checked result.
  pcal_back #(
    .Samples (SAMPLES),
    .SumW    (SumW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_status.empty),
    .q_sum_i     (q_rd_data[SumW-1:0]),
    .q_calc_i    (q_rd_data[SumW]),
    .pop_o       (pop),
    .calib_i     (calib_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // A result flagged valid must lie inside the configured range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.valid_res |->
      (out_item_o.pressure >= calib_q.range_min) &&
      (out_item_o.pressure <= calib_q.range_max))
    else $error("valid result outside the configured range");

  // The queue can only fill up behind a result that waits on the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.full |-> out_valid_o)
    else $error("queue full while the output holds no result");

  // A full queue that was not popped had a stalled output on the cycle before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.full && $past(q_status.full) |-> $past(out_valid_o && !out_ready_i))
    else $error("queue stayed full although the output advanced");

endmodule

FILE: dv/tb_oversampled_pressure_calibrator_core.sv
`timescale 1ns / 1ps

// This testbench checks the pressure calibrator through its input and output channels.
// The checker keeps its own copy of the sample window and of the calibration
// registers. It works out the result of every accepted input transfer and
// compares the results that come back, in order, field by field.
module tb_oversampled_pressure_calibrator_core;
  import pcal_pkg::*;

  // Window depth of the block under test. Results arrive once the input transfer has
  // passed the queue and the back-end pipe, or later when the output is stalled.
  localparam int NumTaps       = 8;
  localparam int ResultLatency = 4;
  // Cycles without any transfer or register write before the run is abandoned.
  localparam int QuietLimit    = 2000;
  localparam int ItemsPerSet   = 60;

  localparam longint PresHi = 64'sd2147483647;
  localparam longint PresLo = -64'sd2147483648;

  // Every input of the block starts at a known value.
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  in_item_t           in_item_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_item_t          out_item_o;
  logic               cfg_we_i    = 1'b0;
  logic [RegIdxW-1:0] cfg_idx_i   = '0;
  logic [RegW-1:0]    cfg_data_i  = '0;

  // Sample window model: ring, write slot, fill count and running sum.
  logic signed [DataW-1:0] window_ring [NumTaps] = '{default: '0};
  int ring_wr_pos  = 0;
  int ring_fill    = 0;
  int window_total = 0;

  // Calibration registers as the block should hold them.
  logic signed [RegW-1:0] cal_scale  = ScaleReset;
  logic signed [RegW-1:0] cal_offset = OffsetReset;
  logic signed [RegW-1:0] cal_lo     = RangeMinReset;
  logic signed [RegW-1:0] cal_hi     = RangeMaxReset;

  // Results still owed by the block, oldest first.
  out_item_t pressure_expect_q [$];

  // Percentages of cycles in which the sender holds back or the receiver stalls.
  int idle_pct     = 0;
  int stall_pct    = 0;
  int err_count    = 0;
  int quiet_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  oversampled_pressure_calibrator_core #(
    .SAMPLES(NumTaps)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Advances the window model by one input and returns the calibrated result.
  // An absent device leaves the window alone and yields a zero, invalid result;
  // a window that has not yet seen NumTaps samples also yields one.
  function automatic out_item_t calibrate_sample(in_item_t it);
    out_item_t               res;
    logic signed [DataW-1:0] s;
    logic signed [RegW-1:0]  pres;
    longint                  avg;
    longint                  prod;
    longint                  p;
    res = '0;
    s = it.sample;
    if (it.device_ok) begin
      window_total = window_total - window_ring[ring_wr_pos] + s;
      window_ring[ring_wr_pos] = s;
      ring_wr_pos = (ring_wr_pos + 1) % NumTaps;
      if (ring_fill < NumTaps) begin
        ring_fill++;
      end
      if (ring_fill >= NumTaps) begin
        // Integer division truncates toward zero; the shift of the product
        // rounds toward minus infinity.
        avg  = window_total / NumTaps;
        prod = avg * longint'(cal_scale);
        p    = (prod >>> ScaleFrac) + longint'(cal_offset);
        if (p > PresHi) begin
          p = PresHi;
        end
        if (p < PresLo) begin
          p = PresLo;
        end
        pres          = p[RegW-1:0];
        res.pressure  = pres;
        res.valid_res = (pres >= cal_lo) && (pres <= cal_hi);
      end
    end
    return res;
  endfunction

  task automatic log_mismatch(input string what, input longint want, input longint got);
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    err_count++;
  endtask

  // The receiver stalls at random at the rate of the current phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // All handshakes are judged on the values present just before the edge, so the
  // order in which processes wake at the edge does not matter. The result check
  // comes before the prediction; the block cannot return a result in the same
  // edge that its input transfer is taken.
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    logic      busy;
    if (rst_ni) begin
      busy = 1'b0;
      if (out_valid_o && out_ready_i) begin
        busy = 1'b1;
        if (pressure_expect_q.size() == 0) begin
          $display("%0t ns: result transfer with nothing expected, %s %0d valid %0b",
                   $time, "actual pressure", $signed(out_item_o.pressure),
                   out_item_o.valid_res);
          err_count++;
        end else begin
          want = pressure_expect_q.pop_front();
          if (out_item_o.pressure !== want.pressure) begin
            log_mismatch("pressure", longint'($signed(want.pressure)),
                         longint'($signed(out_item_o.pressure)));
          end
          if (out_item_o.valid_res !== want.valid_res) begin
            log_mismatch("valid_res", longint'(want.valid_res), longint'(out_item_o.valid_res));
          end
        end
      end
      if (cfg_we_i) begin
        busy = 1'b1;
        case (reg_idx_e'(cfg_idx_i))
          REG_SCALE:     cal_scale  = cfg_data_i;
          REG_OFFSET:    cal_offset = cfg_data_i;
          REG_RANGE_MIN: cal_lo     = cfg_data_i;
          REG_RANGE_MAX: cal_hi     = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        busy = 1'b1;
        pressure_expect_q.push_back(calibrate_sample(in_item_i));
      end
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
      // The watchdog check stays last in this block.
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t ns: no transfer for %0d cycles", $time, QuietLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Offers one input transfer and returns at the edge where it is taken. The
  // sender may first hold back for a random number of cycles.
  task automatic send_sample(input logic signed [DataW-1:0] s, input logic ok);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{sample: s, device_ok: ok};
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
  endtask

  // Leaves the write enable high; set_calib lowers it after the last write.
  task automatic write_reg(input reg_idx_e idx, input logic [RegW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic set_calib(input logic signed [RegW-1:0] sc, input logic signed [RegW-1:0] off,
                           input logic signed [RegW-1:0] lo, input logic signed [RegW-1:0] hi);
    write_reg(REG_SCALE, sc);
    write_reg(REG_OFFSET, off);
    write_reg(REG_RANGE_MIN, lo);
    write_reg(REG_RANGE_MAX, hi);
    cfg_we_i <= 1'b0;
  endtask

  // Stops offering input, waits until every owed result has come back, and lets
  // the pipe run empty before the next register write.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pressure_expect_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (ResultLatency + 2) @(posedge clk_i);
  endtask

  // Signed random value in [-mag, mag].
  function automatic int rand_span(input int mag);
    return int'($urandom_range(2 * mag)) - mag;
  endfunction

  function automatic logic signed [RegW-1:0] pick_coeff();
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(4))
          0: return RangeMaxReset;
          1: return RangeMinReset;
          2: return '0;
          3: return 32'sd1;
          default: return -32'sd1;
        endcase
      end
      1: return rand_span(1 << 18);
      2: return rand_span(1 << 26);
      default: return $urandom;
    endcase
  endfunction

  // With the reset calibration the pressure equals the window average. The
  // window fills over absent-device items; the first full window holds only -2048
  // and the ones after it mix signs so that truncation toward zero shows.
  task automatic test_fill_and_absent();
    send_sample(12'sh7ff, 1'b0);
    repeat (NumTaps - 1) send_sample(-12'sd2048, 1'b1);
    send_sample(12'sh7ff, 1'b0);
    send_sample(-12'sd2048, 1'b1);
    send_sample(12'sd2047, 1'b1);
    send_sample(12'sd2047, 1'b1);
    send_sample(12'sd0, 1'b0);
    wait_idle();
  endtask

  // Drives the scaled value past both ends of the 32-bit range. The window
  // average is negative here, so a negative scale pushes it upward.
  task automatic test_saturation();
    set_calib(RangeMinReset, RangeMaxReset, RangeMinReset, RangeMaxReset);
    send_sample(-12'sd2048, 1'b1);
    send_sample(-12'sd2048, 1'b1);
    send_sample(-12'sd2048, 1'b0);
    wait_idle();
    set_calib(RangeMaxReset, RangeMinReset, RangeMinReset, RangeMaxReset);
    send_sample(-12'sd2048, 1'b1);
    send_sample(-12'sd2048, 1'b1);
    wait_idle();
  endtask

  // A range of one value at -2048, an empty range, and a narrow
  // range the pressure falls outside of, where the pressure is still reported.
  task automatic test_range_limits();
    set_calib(ScaleReset, OffsetReset, -32'sd2048, -32'sd2048);
    repeat (3) send_sample(-12'sd2048, 1'b1);
    wait_idle();
    set_calib(ScaleReset, OffsetReset, 32'sd0, -32'sd1);
    send_sample(12'sd0, 1'b1);
    send_sample(-12'sd2048, 1'b1);
    wait_idle();
    set_calib(ScaleReset, OffsetReset, -32'sd100, 32'sd100);
    send_sample(-12'sd2048, 1'b1);
    send_sample(12'sd2047, 1'b1);
    wait_idle();
  endtask

  // Random calibrations and sample streams under each idling pattern. The first
  // setting of every phase is an extreme one; the device is present in most
  // items so the window stays full and the calibration path is exercised.
  task automatic test_random_traffic();
    int                      pcts [4][2];
    logic signed [RegW-1:0]  sc;
    logic signed [RegW-1:0]  off;
    logic signed [RegW-1:0]  lo;
    logic signed [RegW-1:0]  hi;
    logic signed [RegW-1:0]  a;
    logic signed [RegW-1:0]  b;
    logic signed [DataW-1:0] s;
    int                      walk;
    int                      mode;
    int                      width;
    pcts = '{'{0, 0}, '{72, 0}, '{0, 72}, '{20, 20}};
    walk = 0;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = pcts[ph][0];
      stall_pct = pcts[ph][1];
      for (int k = 0; k < 6; k++) begin
        if (k == 0) begin
          case (ph)
            0: set_calib(RangeMaxReset, RangeMaxReset, RangeMinReset, RangeMaxReset);
            1: set_calib(RangeMinReset, RangeMinReset, RangeMinReset, RangeMaxReset);
            2: set_calib('0, '0, '0, '0);
            default: set_calib(ScaleReset, OffsetReset, RangeMaxReset, RangeMinReset);
          endcase
        end else begin
          sc  = pick_coeff();
          off = pick_coeff();
          case ($urandom_range(3))
            0: begin
              lo = RangeMinReset;
              hi = RangeMaxReset;
            end
            1: begin
              // A window around the offset, so validity changes with the samples.
              width = 1 << $urandom_range(4, 24);
              lo = off + rand_span(width);
              hi = lo + $urandom_range(2 * width);
            end
            2: begin
              a  = $urandom;
              b  = $urandom;
              lo = (a > b) ? a : b + 1;
              hi = (a > b) ? b : a;
            end
            default: begin
              lo = $urandom;
              hi = $urandom;
            end
          endcase
          set_calib(sc, off, lo, hi);
        end
        mode = $urandom_range(2);
        for (int n = 0; n < ItemsPerSet; n++) begin
          case (mode)
            0: s = DataW'($urandom);
            1: begin
              walk = walk + rand_span(64);
              if (walk > 2047) walk = 2047;
              if (walk < -2048) walk = -2048;
              s = DataW'(walk);
            end
            default: begin
              case ($urandom_range(2))
                0: s = 12'sd2047;
                1: s = -12'sd2048;
                default: s = DataW'($urandom);
              endcase
            end
          endcase
          send_sample(s, $urandom_range(99) >= 10);
        end
        wait_idle();
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_and_absent();
    test_saturation();
    test_range_limits();
    test_random_traffic();
    if (pressure_expect_q.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $time, pressure_expect_q.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
